>>> rtl/core/sjms_pkg.sv
// Shared types, symbol codes and motif classification for the splice junction shift core.
package sjms_pkg;

    typedef logic [7:0] t_sym;
    typedef logic [2:0] t_motif;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam t_motif MOTIF_NONE = 3'd0;
    localparam t_motif MOTIF_GTAG = 3'd1;
    localparam t_motif MOTIF_CTAC = 3'd2;
    localparam t_motif MOTIF_GCAG = 3'd3;
    localparam t_motif MOTIF_CTGC = 3'd4;
    localparam t_motif MOTIF_ATAC = 3'd5;
    localparam t_motif MOTIF_GTAT = 3'd6;

    localparam t_sym SYM_A    = 8'h41;
    localparam t_sym SYM_C    = 8'h43;
    localparam t_sym SYM_G    = 8'h47;
    localparam t_sym SYM_T    = 8'h54;
    localparam t_sym SYM_N    = 8'h4E;
    localparam t_sym SYM_HASH = 8'h23;

    function automatic logic is_stop(input t_sym c);
        return (c == SYM_HASH) || (c == SYM_N);
    endfunction

    function automatic t_motif classify(input t_sym a, input t_sym b,
                                        input t_sym c, input t_sym d);
        t_motif m;
        m = MOTIF_NONE;
        if (a == SYM_G && b == SYM_T && c == SYM_A && d == SYM_G) m = MOTIF_GTAG;
        else if (a == SYM_C && b == SYM_T && c == SYM_A && d == SYM_C) m = MOTIF_CTAC;
        else if (a == SYM_G && b == SYM_C && c == SYM_A && d == SYM_G) m = MOTIF_GCAG;
        else if (a == SYM_C && b == SYM_T && c == SYM_G && d == SYM_C) m = MOTIF_CTGC;
        else if (a == SYM_A && b == SYM_T && c == SYM_A && d == SYM_C) m = MOTIF_ATAC;
        else if (a == SYM_G && b == SYM_T && c == SYM_A && d == SYM_T) m = MOTIF_GTAT;
        return m;
    endfunction

endpackage

>>> rtl/core/splice_junction_motif_shift_core.sv
// Splice junction motif and repeat shift core: genome byte store and query sequencer.
//
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_stall    | kind, address, symbol, junction_start/end
//  result  | out       | o_out_valid / i_out_stall  | motif, shifts, shifted coords, range_error
//  config  | in        | i_cfg_we                   | genome_length
//
// A load yields no result and leaves the input unstalled. A query stalls the input from
// acceptance through the motif reads, the left and right walks (each at most MAX_REPEAT
// paired store reads) and S_DONE; its result is registered on leaving S_DONE. Range-error
// queries go from S_IDLE straight to S_DONE. Reset is synchronous; the store is
// not cleared. A result still stalled at the output holds the next query in its final state.
module splice_junction_motif_shift_core
    import sjms_pkg::*;
#(
    parameter longint unsigned GENOME_DEPTH = 1048576,
    parameter int unsigned     MAX_REPEAT   = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [20:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [19:0] i_address,
    input  logic [7:0]  i_symbol,
    input  logic [19:0] i_junction_start,
    input  logic [19:0] i_junction_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_motif,
    output logic [7:0]  o_shift_left,
    output logic [7:0]  o_shift_right,
    output logic [19:0] o_shifted_start,
    output logic [19:0] o_shifted_end,
    output logic        o_range_error
);

    localparam longint unsigned MEM_DEPTH =
        (GENOME_DEPTH < 64'd1048576) ? GENOME_DEPTH : 64'd1048576;
    localparam int unsigned AW = $clog2(MEM_DEPTH);
    localparam logic [21:0] LEN_CAP =
        (GENOME_DEPTH < 64'd2097152) ? 22'(GENOME_DEPTH) : 22'd2097152;
    localparam logic [8:0] MAX_J = 9'(MAX_REPEAT);

    typedef enum logic [2:0] {
        S_IDLE, S_MOT1, S_MOT2, S_LWALK, S_RWALK, S_DONE
    } t_state;

    t_sym r_mem [MEM_DEPTH];

    t_state      r_state;
    logic [20:0] r_cfg_len;
    logic [19:0] r_s, r_e;
    logic [7:0]  r_j, r_jl, r_jr;
    t_sym        r_c0, r_c1, r_qa, r_qb;
    t_motif      r_mot;
    logic        r_range;
    logic        r_out_valid;
    t_motif      r_motif;
    logic [7:0]  r_shift_left, r_shift_right;
    logic [19:0] r_shifted_start, r_shifted_end;
    logic        r_range_error;

    logic [21:0] w_len;
    logic        w_accept, w_match, w_lcond0, w_rcond0, w_lnext, w_rnext, w_out_free;
    logic [7:0]  w_nj;
    logic [19:0] w_ra, w_rb;

    function automatic logic lcond(input logic [7:0] j, input logic [19:0] s);
        return (9'(j) < MAX_J) && ((21'(j) + 21'd1) < 21'(s));
    endfunction

    function automatic logic rcond(input logic [7:0] j, input logic [19:0] e,
                                   input logic [21:0] len);
        return (9'(j) < MAX_J) && ((22'(e) + 22'(j) + 22'd1) < len);
    endfunction

    assign w_len      = ({1'b0, r_cfg_len} > LEN_CAP) ? LEN_CAP : {1'b0, r_cfg_len};
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_match    = (r_qa == r_qb) && !is_stop(r_qa);
    assign w_nj       = r_j + 8'd1;
    assign w_lcond0   = lcond(8'd0, r_s);
    assign w_rcond0   = rcond(8'd0, r_e, w_len);
    assign w_lnext    = w_match && lcond(w_nj, r_s);
    assign w_rnext    = w_match && rcond(w_nj, r_e, w_len);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_ra = '0;
        w_rb = '0;
        case (r_state)
            S_IDLE: begin
                w_ra = i_junction_start;
                w_rb = i_junction_start + 20'd1;
            end
            S_MOT1: begin
                w_ra = r_e - 20'd1;
                w_rb = r_e;
            end
            S_MOT2: begin
                if (w_lcond0) begin
                    w_ra = r_s - 20'd1;
                    w_rb = r_e;
                end else begin
                    w_ra = r_s;
                    w_rb = r_e + 20'd1;
                end
            end
            S_LWALK: begin
                if (w_lnext) begin
                    w_ra = r_s - 20'(w_nj) - 20'd1;
                    w_rb = r_e - 20'(w_nj);
                end else begin
                    w_ra = r_s;
                    w_rb = r_e + 20'd1;
                end
            end
            S_RWALK: begin
                w_ra = r_s + 20'(w_nj);
                w_rb = r_e + 20'(w_nj) + 20'd1;
            end
            default: begin
                w_ra = '0;
                w_rb = '0;
            end
        endcase
    end

    // genome store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_accept && i_kind == KIND_LOAD && 64'(i_address) < GENOME_DEPTH) begin
            r_mem[i_address[AW-1:0]] <= i_symbol;
        end
        r_qa <= r_mem[w_ra[AW-1:0]];
        r_qb <= r_mem[w_rb[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cfg_len   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_len <= i_cfg_wdata;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_kind == KIND_QUERY) begin
                        r_s <= i_junction_start;
                        r_e <= i_junction_end;
                        if (i_junction_start == '0 || i_junction_end <= i_junction_start
                            || 22'(i_junction_end) >= w_len) begin
                            r_range <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_range <= 1'b0;
                            r_state <= S_MOT1;
                        end
                    end
                end
                S_MOT1: begin
                    r_c0    <= r_qa;
                    r_c1    <= r_qb;
                    r_state <= S_MOT2;
                end
                S_MOT2: begin
                    r_mot <= classify(r_c0, r_c1, r_qa, r_qb);
                    r_j   <= '0;
                    if (w_lcond0) begin
                        r_state <= S_LWALK;
                    end else begin
                        r_jl    <= '0;
                        r_jr    <= '0;
                        r_state <= w_rcond0 ? S_RWALK : S_DONE;
                    end
                end
                S_LWALK: begin
                    if (w_lnext) begin
                        r_j <= w_nj;
                    end else begin
                        r_jl    <= w_match ? w_nj : r_j;
                        r_j     <= '0;
                        r_jr    <= '0;
                        r_state <= w_rcond0 ? S_RWALK : S_DONE;
                    end
                end
                S_RWALK: begin
                    if (w_rnext) begin
                        r_j <= w_nj;
                    end else begin
                        r_jr    <= w_match ? w_nj : r_j;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        if (r_range) begin
                            r_motif         <= MOTIF_NONE;
                            r_shift_left    <= '0;
                            r_shift_right   <= '0;
                            r_shifted_start <= '0;
                            r_shifted_end   <= '0;
                            r_range_error   <= 1'b1;
                        end else begin
                            r_motif         <= r_mot;
                            r_shift_left    <= r_jl;
                            r_shift_right   <= r_jr;
                            r_shifted_start <= r_s - 20'(r_jl);
                            r_shifted_end   <= r_e - 20'(r_jl);
                            r_range_error   <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_motif         = r_motif;
    assign o_shift_left    = r_shift_left;
    assign o_shift_right   = r_shift_right;
    assign o_shifted_start = r_shifted_start;
    assign o_shifted_end   = r_shifted_end;
    assign o_range_error   = r_range_error;

endmodule

>>> rtl/core/sjms_checker.sv
// Port-level checker for the splice junction shift core, bound to the core module.
module sjms_checker
    import sjms_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_kind,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_motif,
    input logic [7:0]  o_shift_left,
    input logic [7:0]  o_shift_right,
    input logic [19:0] o_shifted_start,
    input logic [19:0] o_shifted_end,
    input logic        o_range_error
);

    // result transaction holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error) |-> (o_motif == MOTIF_NONE && o_shift_left == 8'd0
            && o_shift_right == 8'd0 && o_shifted_start == 20'd0 && o_shifted_end == 20'd0))
        else $error("range error result carries nonzero fields");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_range_error) |-> (o_shifted_end > o_shifted_start))
        else $error("shifted end not above shifted start");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_kind == KIND_QUERY) |=> o_in_stall)
        else $error("query transaction did not occupy the core");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_kind == KIND_LOAD) |=> !o_in_stall)
        else $error("load transaction stalled the input");

endmodule

bind splice_junction_motif_shift_core sjms_checker u_sjms_checker (.*);

>>> verif/splice_junction_motif_shift_core_tb.sv
// Testbench for the splice junction motif and repeat shift core: stored genome, queries, scoreboard.
module splice_junction_motif_shift_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sjms_pkg::*;

    localparam int unsigned STORE_DEPTH = 1048576;
    localparam int unsigned WALK_LIMIT  = 255;
    localparam int unsigned TOTAL_ITEMS = 1150;
    localparam t_sym BASES [4] = '{SYM_A, SYM_C, SYM_G, SYM_T};

    typedef struct packed {
        t_motif      motif;
        logic [7:0]  shift_left;
        logic [7:0]  shift_right;
        logic [19:0] shifted_start;
        logic [19:0] shifted_end;
        logic        range_error;
    } junction_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [20:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        in_kind = KIND_LOAD;
    logic [19:0] in_address = '0;
    t_sym        in_symbol = '0;
    logic [19:0] in_junction_start = '0;
    logic [19:0] in_junction_end = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_motif      out_motif;
    logic [7:0]  out_shift_left;
    logic [7:0]  out_shift_right;
    logic [19:0] out_shifted_start;
    logic [19:0] out_shifted_end;
    logic        out_range_error;

    t_sym             genome_mem [int unsigned];
    logic [20:0]      genome_len_cfg = '0;
    junction_result_t pending_junctions [$];
    int               items_sent = 0;
    int               mismatches = 0;
    bit               steady = 1'b0;

    splice_junction_motif_shift_core #(
        .GENOME_DEPTH(STORE_DEPTH),
        .MAX_REPEAT  (WALK_LIMIT)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_kind          (in_kind),
        .i_address       (in_address),
        .i_symbol        (in_symbol),
        .i_junction_start(in_junction_start),
        .i_junction_end  (in_junction_end),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_motif         (out_motif),
        .o_shift_left    (out_shift_left),
        .o_shift_right   (out_shift_right),
        .o_shifted_start (out_shifted_start),
        .o_shifted_end   (out_shifted_end),
        .o_range_error   (out_range_error)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] canonical_letters(input t_motif m);
        case (m)
            MOTIF_GTAG: return {SYM_G, SYM_T, SYM_A, SYM_G};
            MOTIF_CTAC: return {SYM_C, SYM_T, SYM_A, SYM_C};
            MOTIF_GCAG: return {SYM_G, SYM_C, SYM_A, SYM_G};
            MOTIF_CTGC: return {SYM_C, SYM_T, SYM_G, SYM_C};
            MOTIF_ATAC: return {SYM_A, SYM_T, SYM_A, SYM_C};
            MOTIF_GTAT: return {SYM_G, SYM_T, SYM_A, SYM_T};
            default:    return '0;
        endcase
    endfunction

    function automatic t_motif motif_of(input logic [31:0] quad);
        for (t_motif m = MOTIF_GTAG; m <= MOTIF_GTAT; m++) begin
            if (canonical_letters(m) == quad) return m;
        end
        return MOTIF_NONE;
    endfunction

    function automatic bit halts_walk(input t_sym c);
        return (c == SYM_HASH) || (c == SYM_N);
    endfunction

    // missed is set when a position that was never loaded would be read
    function automatic t_sym peek_genome(input int unsigned pos, inout bit missed);
        if (genome_mem.exists(pos)) return genome_mem[pos];
        missed = 1'b1;
        return '0;
    endfunction

    function automatic junction_result_t predict_junction(input logic [19:0] start_pos,
                                                          input logic [19:0] end_pos,
                                                          output bit missed);
        junction_result_t r;
        int unsigned s, e, span, jl, jr;
        t_sym a, b;
        r = '0;
        missed = 1'b0;
        s = start_pos;
        e = end_pos;
        span = (genome_len_cfg > STORE_DEPTH) ? STORE_DEPTH : genome_len_cfg;
        if (s == 0 || e <= s || e >= span) begin
            r.range_error = 1'b1;
            return r;
        end
        r.motif = motif_of({peek_genome(s, missed), peek_genome(s + 1, missed),
                            peek_genome(e - 1, missed), peek_genome(e, missed)});
        jl = 0;
        while (jl < WALK_LIMIT && jl + 1 < s) begin
            a = peek_genome(s - 1 - jl, missed);
            b = peek_genome(e - jl, missed);
            if (a != b || halts_walk(a)) break;
            jl++;
        end
        jr = 0;
        while (jr < WALK_LIMIT && e + 1 + jr < span) begin
            a = peek_genome(s + jr, missed);
            b = peek_genome(e + 1 + jr, missed);
            if (a != b || halts_walk(a)) break;
            jr++;
        end
        r.shift_left    = jl[7:0];
        r.shift_right   = jr[7:0];
        r.shifted_start = 20'(s - jl);
        r.shifted_end   = 20'(e - jl);
        return r;
    endfunction

    function automatic t_sym noise_symbol();
        case ($urandom_range(0, 3))
            0:       return SYM_HASH;
            1:       return SYM_N;
            2:       return 8'($urandom);
            default: return BASES[$urandom_range(0, 3)];
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        if (mismatches < 100)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_transaction(input logic kind, input logic [19:0] addr, input t_sym sym,
                                    input logic [19:0] start_pos, input logic [19:0] end_pos);
        int gap;
        bit missed;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_kind           <= kind;
        in_address        <= addr;
        in_symbol         <= sym;
        in_junction_start <= start_pos;
        in_junction_end   <= end_pos;
        in_valid          <= 1'b1;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (kind == KIND_LOAD) begin
            genome_mem[addr] = sym;
        end else begin
            pending_junctions.insert(pending_junctions.size(),
                                     predict_junction(start_pos, end_pos, missed));
        end
    endtask

    task automatic load_symbol(input logic [19:0] addr, input t_sym sym);
        send_transaction(KIND_LOAD, addr, sym, 20'($urandom), 20'($urandom));
    endtask

    task automatic query_junction(input logic [19:0] start_pos, input logic [19:0] end_pos);
        send_transaction(KIND_QUERY, 20'($urandom), 8'($urandom), start_pos, end_pos);
    endtask

    // only sends the query when every position it reads has been loaded
    task automatic try_query(input logic [19:0] start_pos, input logic [19:0] end_pos,
                             output bit ok);
        bit missed;
        void'(predict_junction(start_pos, end_pos, missed));
        ok = !missed;
        if (ok) query_junction(start_pos, end_pos);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_junctions.size() != 0);
    endtask

    task automatic set_genome_length(input logic [20:0] value);
        drain_results();
        repeat (16) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        genome_len_cfg = value;
    endtask

    // periodic sequence bounded by stop symbols so repeat walks end inside loaded data
    task automatic load_periodic(input int unsigned base, input int unsigned n,
                                 input int unsigned period, input bit noisy);
        t_sym unit [16];
        t_sym sym;
        for (int i = 0; i < 16; i++) unit[i] = BASES[$urandom_range(0, 3)];
        if (base > 0)
            load_symbol(20'(base - 1), $urandom_range(0, 1) ? SYM_HASH : SYM_N);
        if (base + n < STORE_DEPTH)
            load_symbol(20'(base + n), $urandom_range(0, 1) ? SYM_HASH : SYM_N);
        for (int unsigned i = 0; i < n; i++) begin
            sym = unit[i % period];
            if (noisy && $urandom_range(0, 39) == 0) sym = noise_symbol();
            load_symbol(20'(base + i), sym);
        end
    endtask

    task automatic probe_window(input int unsigned base, input int unsigned n,
                                input int unsigned period, input int unsigned count);
        int unsigned s, e, k, kmax, pick;
        logic [31:0] quad;
        bit ok;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            s = base + $urandom_range(0, n - 1);
            kmax = (base + n - s) / period;
            k = (kmax == 0) ? 0 : $urandom_range(1, kmax);
            e = s - 1 + k * period;
            if (pick < 15) begin
                e = base + $urandom_range(0, n - 1);
            end else if (pick < 25) begin
                case ($urandom_range(0, 3))
                    0: s = 0;
                    1: e = s;
                    2: e = genome_len_cfg + $urandom_range(0, 3);
                    default: begin
                        s = $urandom;
                        e = $urandom;
                    end
                endcase
            end else if (pick < 35) begin
                load_symbol(20'(base + $urandom_range(0, n - 1)), noise_symbol());
            end else if (pick < 45) begin
                quad = canonical_letters(t_motif'($urandom_range(MOTIF_GTAG, MOTIF_GTAT)));
                load_symbol(20'(s), quad[31:24]);
                load_symbol(20'(s + 1), quad[23:16]);
                load_symbol(20'(e - 1), quad[15:8]);
                load_symbol(20'(e), quad[7:0]);
            end
            if (pick < 25 || pick >= 35) begin
                try_query(20'(s), 20'(e), ok);
                if (!ok) query_junction(0, 20'($urandom));
            end
        end
    endtask

    task automatic test_motif_classes();
        string layout;
        layout = "#GTCTGCATAGACNAT";
        query_junction(5, 9);
        set_genome_length(21'd16);
        for (int i = 0; i < layout.len(); i++) load_symbol(20'(i), layout[i]);
        query_junction(1, 10);
        query_junction(3, 12);
        query_junction(5, 10);
        query_junction(3, 6);
        query_junction(7, 12);
        query_junction(1, 15);
        query_junction(2, 9);
        query_junction(0, 5);
        query_junction(5, 5);
        query_junction(9, 4);
        query_junction(2, 16);
    endtask

    task automatic test_length_extremes();
        int unsigned base, period;
        bit ok;
        base = STORE_DEPTH - 48;
        period = $urandom_range(1, 5);
        set_genome_length('0);
        query_junction(20'hFFFFF, 20'hFFFFF);
        query_junction(1, 20'hFFFFF);
        query_junction(3, 9);
        load_periodic(base, 48, period, 1'b0);
        set_genome_length(21'h1FFFFF);
        try_query(20'(base + 8), 20'hFFFFF, ok);
        probe_window(base, 48, period, 10);
        set_genome_length(21'(STORE_DEPTH));
        try_query(20'(base + 20), 20'hFFFFE, ok);
        probe_window(base, 48, period, 6);
        set_genome_length(21'(STORE_DEPTH - 1));
        query_junction(20'(base + 8), 20'hFFFFF);
        probe_window(base, 48, period, 6);
    endtask

    task automatic test_repeat_saturation();
        int unsigned base, period, s, e;
        bit ok;
        base = 4000;
        period = $urandom_range(1, 6);
        s = base + 270;
        e = s - 1 + period * (20 / period + 1);
        load_periodic(base, 560, period, 1'b0);
        set_genome_length(21'd65536);
        steady = 1'b1;
        try_query(20'(s), 20'(e), ok);
        try_query(20'(s + period), 20'(e + period), ok);
        set_genome_length(21'(e + 11));
        try_query(20'(s), 20'(e), ok);
        set_genome_length(21'd65536);
        load_symbol(20'(s - 41), SYM_HASH);
        load_symbol(20'(e - 40), SYM_HASH);
        try_query(20'(s), 20'(e), ok);
        load_symbol(20'(s + 17), SYM_N);
        load_symbol(20'(e + 18), SYM_N);
        try_query(20'(s), 20'(e), ok);
        load_symbol(20'(e + 6), genome_mem[s + 5] ^ 8'h01);
        try_query(20'(s), 20'(e), ok);
        steady = 1'b0;
        probe_window(base, 560, period, 16);
    endtask

    task automatic test_random_windows();
        int unsigned base, n, period;
        logic [20:0] len;
        while (items_sent < TOTAL_ITEMS) begin
            steady = ($urandom_range(0, 3) == 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 300) : $urandom_range(12, 80);
            case ($urandom_range(0, 9))
                0, 1, 2: base = 0;
                3, 4:    base = STORE_DEPTH - n;
                default: base = $urandom_range(0, STORE_DEPTH - n);
            endcase
            period = $urandom_range(1, 12);
            load_periodic(base, n, period, $urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0, 1:    len = 21'(base + n);
                2:       len = 21'(base + n - $urandom_range(0, n / 2));
                3:       len = 21'($urandom);
                4:       len = 21'(STORE_DEPTH);
                default: len = 21'h1FFFFF;
            endcase
            set_genome_length(len);
            probe_window(base, n, period, $urandom_range(8, 30));
            if ($urandom_range(0, 3) == 0) drain_results();
        end
        steady = 1'b0;
    endtask

    initial begin : result_sink
        int hold;
        forever begin
            hold = steady ? 0 : $urandom_range(0, 11);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    always @(posedge clk) begin : result_check
        junction_result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (pending_junctions.size() == 0) begin
                flag_mismatch("unexpected transaction", 1, 0);
            end else begin
                want = pending_junctions.pop_front();
                if (out_motif !== want.motif)
                    flag_mismatch("motif", out_motif, want.motif);
                if (out_shift_left !== want.shift_left)
                    flag_mismatch("shift_left", out_shift_left, want.shift_left);
                if (out_shift_right !== want.shift_right)
                    flag_mismatch("shift_right", out_shift_right, want.shift_right);
                if (out_shifted_start !== want.shifted_start)
                    flag_mismatch("shifted_start", out_shifted_start, want.shifted_start);
                if (out_shifted_end !== want.shifted_end)
                    flag_mismatch("shifted_end", out_shifted_end, want.shifted_end);
                if (out_range_error !== want.range_error)
                    flag_mismatch("range_error", out_range_error, want.range_error);
            end
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_motif_classes();
        test_length_extremes();
        test_repeat_saturation();
        test_random_windows();
        drain_results();
        repeat (600) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/sjms_pkg.sv
rtl/core/splice_junction_motif_shift_core.sv
rtl/core/sjms_checker.sv
verif/splice_junction_motif_shift_core_tb.sv
